### rtl/core/coap_option_header_parser_assert.svh
// Assertion macros for the CoAP option header parser.
// Each check is sampled on the rising edge of clk_i.
// COHP_ASSERT is disabled while rst_ni is low; COHP_ASSERT_ALWAYS is not.
`ifndef COAP_OPTION_HEADER_PARSER_ASSERT_SVH
`define COAP_OPTION_HEADER_PARSER_ASSERT_SVH

`ifndef SYNTHESIS
`define COHP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define COHP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define COHP_ASSERT(lbl, prop, msg)
`define COHP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### rtl/core/cohp_pkg.sv
package cohp_pkg;

  localparam int unsigned KNOWN_OPTIONS = 15;
  localparam int unsigned TABLE_ENTRIES_DEF = 15;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [16:0] EXT1_BIAS = 17'd13;
  localparam logic [16:0] EXT2_BIAS = 17'd269;

  typedef enum logic [3:0] {
    ST_OPTION     = 4'd0,
    ST_PAYLOAD    = 4'd1,
    ST_END        = 4'd2,
    ST_TRUNCATED  = 4'd3,
    ST_RESERVED   = 4'd4,
    ST_BAD_MARKER = 4'd5,
    ST_REPEATED   = 4'd6,
    ST_UNKNOWN    = 4'd7,
    ST_OVERFLOW   = 4'd8
  } status_e;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_DEXT,
    PH_DLO,
    PH_LEXT,
    PH_LLO,
    PH_VALUE,
    PH_DRAIN
  } phase_e;

  // What the front end hands over for one byte.
  typedef enum logic [1:0] {
    EV_HDR,
    EV_STOP,
    EV_END,
    EV_NOP
  } ev_kind_e;

  typedef struct packed {
    ev_kind_e    kind;
    status_e     status;
    logic [16:0] delta;
    logic [16:0] len;
    logic        last;
  } event_t;

  typedef struct packed {
    logic found;
    logic rep;
  } lookup_t;

  localparam logic [15:0] OPT_NUM [KNOWN_OPTIONS] = '{
    16'd1, 16'd3, 16'd4, 16'd5, 16'd7, 16'd8, 16'd11, 16'd12,
    16'd14, 16'd15, 16'd17, 16'd20, 16'd35, 16'd39, 16'd60
  };
  localparam logic OPT_REP [KNOWN_OPTIONS] = '{
    1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0,
    1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0
  };

  // Match a number against the first 'entries' rows of the option table.
  function automatic lookup_t opt_lookup(input logic [15:0] num,
                                         input int unsigned entries);
    lookup_t r;
    r = '0;
    for (int unsigned i = 0; i < KNOWN_OPTIONS; i++) begin
      if (i < entries && OPT_NUM[i] == num) begin
        r.found = 1'b1;
        r.rep   = OPT_REP[i];
      end
    end
    return r;
  endfunction

endpackage

### rtl/core/cohp_front.sv
module cohp_front import cohp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  input  logic       ready_i,
  output logic       push_o,
  output event_t     event_o
);

  phase_e      phase_q, phase_d;
  logic [16:0] delta_q, delta_d;
  logic [3:0]  len_nib_q, len_nib_d;
  logic [7:0]  hi_q, hi_d;
  logic [15:0] remain_q, remain_d;

  logic        accept;
  logic [3:0]  nib_hi, nib_lo;
  logic        push_req;
  ev_kind_e    ev_kind;
  status_e     ev_status;
  logic [16:0] dval;
  logic [16:0] hdr_len;
  logic [3:0]  ln;
  logic        need_after;
  phase_e      wait_phase;
  logic [15:0] remain_dec;

  assign accept = valid_i & ready_i;
  assign nib_hi = byte_i[7:4];
  assign nib_lo = byte_i[3:0];

  // Classify the byte against the current header phase.
  always_comb begin
    push_req   = 1'b0;
    ev_kind    = EV_NOP;
    ev_status  = ST_OPTION;
    dval       = delta_q;
    hdr_len    = '0;
    ln         = len_nib_q;
    need_after = 1'b0;
    wait_phase = phase_q;
    case (phase_q)
      PH_HEADER: begin
        dval = {13'd0, nib_hi};
        ln   = nib_lo;
        if (nib_hi == 4'd15) begin
          push_req  = 1'b1;
          ev_kind   = EV_STOP;
          ev_status = (nib_lo == 4'd15) ? ST_PAYLOAD : ST_BAD_MARKER;
        end else if (nib_hi == 4'd13 || nib_hi == 4'd14) begin
          if (last_i) begin
            push_req  = 1'b1;
            ev_kind   = EV_STOP;
            ev_status = ST_TRUNCATED;
          end else begin
            wait_phase = PH_DEXT;
          end
        end else begin
          need_after = 1'b1;
        end
      end
      PH_DEXT: begin
        if (delta_q == 17'd13) begin
          dval       = {9'd0, byte_i} + EXT1_BIAS;
          need_after = 1'b1;
        end else if (last_i) begin
          push_req  = 1'b1;
          ev_kind   = EV_STOP;
          ev_status = ST_TRUNCATED;
        end else begin
          wait_phase = PH_DLO;
        end
      end
      PH_DLO: begin
        dval       = {1'b0, hi_q, byte_i} + EXT2_BIAS;
        need_after = 1'b1;
      end
      PH_LEXT: begin
        if (len_nib_q == 4'd13) begin
          push_req = 1'b1;
          ev_kind  = EV_HDR;
          hdr_len  = {9'd0, byte_i} + EXT1_BIAS;
        end else if (last_i) begin
          push_req  = 1'b1;
          ev_kind   = EV_STOP;
          ev_status = ST_TRUNCATED;
        end else begin
          wait_phase = PH_LLO;
        end
      end
      PH_LLO: begin
        push_req = 1'b1;
        ev_kind  = EV_HDR;
        hdr_len  = {1'b0, hi_q, byte_i} + EXT2_BIAS;
      end
      PH_VALUE: begin
        if (last_i) begin
          push_req  = 1'b1;
          ev_kind   = EV_END;
          ev_status = ST_END;
        end
      end
      PH_DRAIN: begin
        if (last_i) begin
          push_req = 1'b1;
          ev_kind  = EV_NOP;
        end
      end
      default: begin
        push_req = 1'b0;
      end
    endcase

    // Delta is complete: look at the length nibble.
    if (need_after) begin
      if (ln == 4'd15) begin
        push_req  = 1'b1;
        ev_kind   = EV_STOP;
        ev_status = ST_RESERVED;
      end else if (ln == 4'd13 || ln == 4'd14) begin
        if (last_i) begin
          push_req  = 1'b1;
          ev_kind   = EV_STOP;
          ev_status = ST_TRUNCATED;
        end else begin
          wait_phase = PH_LEXT;
        end
      end else begin
        push_req = 1'b1;
        ev_kind  = EV_HDR;
        hdr_len  = {13'd0, ln};
      end
    end
  end

  assign remain_dec = (remain_q != 16'd0) ? remain_q - 16'd1 : remain_q;

  // Next phase and header fields.
  always_comb begin
    phase_d   = phase_q;
    delta_d   = delta_q;
    len_nib_d = len_nib_q;
    hi_d      = hi_q;
    remain_d  = remain_q;
    if (accept) begin
      delta_d = dval;
      if (phase_q == PH_HEADER) begin
        len_nib_d = nib_lo;
      end
      if (wait_phase == PH_DLO || wait_phase == PH_LLO) begin
        hi_d = byte_i;
      end
      if (last_i) begin
        phase_d = PH_HEADER;
      end else if (push_req) begin
        if (ev_kind == EV_STOP) begin
          phase_d = PH_DRAIN;
        end else if (hdr_len == 17'd0) begin
          phase_d = PH_HEADER;
        end else begin
          phase_d  = PH_VALUE;
          remain_d = hdr_len[15:0];
        end
      end else if (phase_q == PH_VALUE) begin
        remain_d = remain_dec;
        phase_d  = (remain_dec == 16'd0) ? PH_HEADER : PH_VALUE;
      end else begin
        phase_d = wait_phase;
      end
    end
  end

  // Transaction toward the queue.
  always_comb begin
    push_o         = accept & push_req;
    event_o.kind   = ev_kind;
    event_o.status = ev_status;
    event_o.delta  = dval;
    event_o.len    = hdr_len;
    event_o.last   = last_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    delta_q   <= delta_d;
    len_nib_q <= len_nib_d;
    hi_q      <= hi_d;
    remain_q  <= remain_d;
  end

endmodule

### rtl/core/cohp_queue.sv
module cohp_queue import cohp_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  event_t data_i,
  output logic   full_o,
  input  logic   pop_i,
  output event_t data_o,
  output logic   empty_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  event_t           slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_FULL);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_LAST) ? '0 : wr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_LAST) ? '0 : rd_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= data_i;
    end
  end

endmodule

### rtl/core/cohp_back.sv
module cohp_back import cohp_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  event_t      event_i,
  output logic        pop_o,
  output logic        valid_o,
  input  logic        ready_i,
  output status_e     status_o,
  output logic [15:0] number_o,
  output logic [15:0] length_o,
  output logic        rep_o,
  output logic        done_o
);

  logic [15:0] run_q, run_d;
  logic        prev_valid_q, prev_valid_d;
  logic        prev_rep_q, prev_rep_d;
  logic        drain_q, drain_d;
  logic        out_valid_q, out_valid_d;

  status_e     out_status_q, out_status_d;
  logic [15:0] out_num_q, out_num_d;
  logic [15:0] out_len_q, out_len_d;
  logic        out_rep_q, out_rep_d;
  logic        out_done_q, out_done_d;

  logic [17:0] sum;
  lookup_t     hit;
  logic        emit;
  status_e     res_status;
  logic        res_ok;

  assign pop_o = ~empty_i & (~out_valid_q | ready_i);
  assign sum   = {2'b00, run_q} + {1'b0, event_i.delta};
  assign hit   = opt_lookup(sum[15:0], TABLE_ENTRIES);

  // Checks on a finished header: repeated, then overflow, then unknown.
  always_comb begin
    res_ok     = 1'b0;
    res_status = event_i.status;
    case (event_i.kind)
      EV_HDR: begin
        if (event_i.delta == 17'd0 && prev_valid_q && !prev_rep_q) begin
          res_status = ST_REPEATED;
        end else if (sum[17:16] != 2'b00 || event_i.len[16]) begin
          res_status = ST_OVERFLOW;
        end else if (!hit.found) begin
          res_status = ST_UNKNOWN;
        end else begin
          res_status = ST_OPTION;
          res_ok     = 1'b1;
        end
      end
      EV_END:  res_status = ST_END;
      default: res_status = event_i.status;
    endcase
  end

  always_comb begin
    run_d        = run_q;
    prev_valid_d = prev_valid_q;
    prev_rep_d   = prev_rep_q;
    drain_d      = drain_q;
    emit         = 1'b0;
    out_status_d = out_status_q;
    out_num_d    = out_num_q;
    out_len_d    = out_len_q;
    out_rep_d    = out_rep_q;
    out_done_d   = out_done_q;
    if (pop_o) begin
      if (!drain_q && event_i.kind != EV_NOP) begin
        emit         = 1'b1;
        out_status_d = res_status;
        out_num_d    = res_ok ? sum[15:0] : 16'd0;
        out_len_d    = res_ok ? event_i.len[15:0] : 16'd0;
        out_rep_d    = res_ok & hit.rep;
        out_done_d   = res_ok ? event_i.last : 1'b1;
        if (res_ok) begin
          run_d        = sum[15:0];
          prev_valid_d = 1'b1;
          prev_rep_d   = hit.rep;
        end else begin
          drain_d = 1'b1;
        end
      end
      // The buffer's final byte wipes all parse state.
      if (event_i.last) begin
        run_d        = '0;
        prev_valid_d = 1'b0;
        prev_rep_d   = 1'b0;
        drain_d      = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q        <= '0;
      prev_valid_q <= 1'b0;
      prev_rep_q   <= 1'b0;
      drain_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      run_q        <= run_d;
      prev_valid_q <= prev_valid_d;
      prev_rep_q   <= prev_rep_d;
      drain_q      <= drain_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_num_q    <= out_num_d;
    out_len_q    <= out_len_d;
    out_rep_q    <= out_rep_d;
    out_done_q   <= out_done_d;
  end

  assign valid_o  = out_valid_q;
  assign status_o = out_status_q;
  assign number_o = out_num_q;
  assign length_o = out_len_q;
  assign rep_o    = out_rep_q;
  assign done_o   = out_done_q;

endmodule

### rtl/core/coap_option_header_parser.sv
// Channel   Dir  tdata                              tuser        tlast
// s_axis    in   [7:0] data_byte                    -            last_byte
// m_axis    out  [15:0] option_number,              [3:0] status message_done
//                [31:16] option_length, [32] repeatable
//
// One byte is taken every cycle while the event queue has room; the front
// parser decodes a byte in the cycle it is accepted.
// A result is registered at the clock edge on which the queue hands its event
// to the back end; a byte reaches it through the queue slot and that register.
// The back end (running number, option table match) works one event a cycle
// unless m_axis stalls, which fills the two-entry queue and drops s_axis_tready.
// Reset (rst_ni low, asynchronous) returns the parser to awaiting a header.
`include "coap_option_header_parser_assert.svh"

module coap_option_header_parser import cohp_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [15:0] number, [31:16] length, [32] repeatable
  output logic [3:0]  m_axis_tuser,   // [3:0] status
  output logic        m_axis_tlast
);

  logic        q_push, q_full, q_pop, q_empty;
  event_t      q_in, q_out;
  status_e     res_status;
  logic [15:0] res_num, res_len;
  logic        res_rep;

  // Hold off the source only while the queue is full.
  assign s_axis_tready = ~q_full;

  cohp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .byte_i  (s_axis_tdata),
    .last_i  (s_axis_tlast),
    .ready_i (s_axis_tready),
    .push_o  (q_push),
    .event_o (q_in)
  );

  cohp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_out),
    .empty_o (q_empty)
  );

  cohp_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (q_empty),
    .event_i  (q_out),
    .pop_o    (q_pop),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .status_o (res_status),
    .number_o (res_num),
    .length_o (res_len),
    .rep_o    (res_rep),
    .done_o   (m_axis_tlast)
  );

  // Pack the result transaction; pad tdata to whole bytes.
  assign m_axis_tdata = {7'd0, res_rep, res_len, res_num};
  assign m_axis_tuser = res_status;

  `COHP_ASSERT(a_push_has_room, q_push |-> !q_full, "event pushed into a full queue")
  `COHP_ASSERT(a_pop_not_empty, q_pop |-> !q_empty, "event popped from an empty queue")
  `COHP_ASSERT(a_stop_fields_zero, m_axis_tvalid && m_axis_tuser != ST_OPTION |-> m_axis_tdata == 40'd0, "non-option result carries option fields")
  `COHP_ASSERT(a_stop_marks_done, m_axis_tvalid && m_axis_tuser != ST_OPTION |-> m_axis_tlast, "terminal result without message_done")

endmodule
